// File: rtl/tcw_pkg.sv
// Package for the text console writer: character codes, reset values and register indexes.
`default_nettype none

package tcw_pkg;

    // Default geometry limits of the cell store.
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 128;

    // Control characters and the blank character.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Register reset values.
    localparam logic [7:0] RESET_ATTR = 8'h1E;
    localparam logic [5:0] RESET_ROWS = 6'd25;
    localparam logic [7:0] RESET_COLS = 8'd80;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_ATTR = 2'd2;

    // Item function codes.
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

endpackage

`default_nettype wire

// File: rtl/text_console_writer_top.sv
// Text console writer: cell store in one memory, cursor, scrolling and cell reads.
// An accepted beat passes normalization (one top-row subtraction per step after a rows change),
// execution, a read wait for a read inside the screen, a sweep of MAX_COLS cells for a scroll,
// and the done state, which loads the result register. One item at a time: the next beat
// is taken only once that result is loaded, later while the result register waits on m_ready.
// After reset a clearing pass blanks all MAX_ROWS * 2**clog2(MAX_COLS) cells (4096 by default).
`default_nettype none

module text_console_writer_top #(
    parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration port.
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // Input channel.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [4:0]  s_read_row,
    input  wire logic [6:0]  s_read_col,
    // Result channel.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_cursor_row,
    output logic [6:0]       m_cursor_col,
    output logic [11:0]      m_cursor_address,
    output logic [7:0]       m_read_char,
    output logic [7:0]       m_read_attr,
    output logic             m_scrolled
);

    // The clearing pass takes no input beat; configuration writes are taken during it.

    // Index and count widths.
    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int PW    = RIW + 1;
    localparam int AW    = RIW + CIW;
    localparam int DEPTH = MAX_ROWS << CIW;
    localparam int AFW   = RIW + CW + 1;
    // Compare widths wide enough for the register, the limit and the read coordinates.
    localparam int RCMPW = 7;
    localparam int CCMPW = 9;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_NORM   = 3'd2;
    localparam logic [2:0] ST_EXEC   = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;
    localparam logic [2:0] ST_SCROLL = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]     state_reg, state_next;

    // Configuration registers.
    logic [5:0]     rows_reg;
    logic [7:0]     cols_reg;
    logic [7:0]     attr_reg;

    // Console state.
    logic [RIW-1:0] top_reg, top_next;
    logic [RIW-1:0] row_reg, row_next;
    logic [CIW-1:0] col_reg, col_next;

    // Captured item and its partial result.
    logic           func_reg;
    logic [7:0]     char_reg;
    logic [4:0]     rrow_reg;
    logic [6:0]     rcol_reg;
    logic [7:0]     rchar_reg, rchar_next;
    logic [7:0]     rattr_reg, rattr_next;
    logic           scr_reg, scr_next;

    // Sweep counters for the clearing pass and for a row blank.
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [CIW-1:0] swp_cnt_reg, swp_cnt_next;
    logic [RIW-1:0] blank_row_reg, blank_row_next;

    // Output register.
    logic           m_valid_reg, m_valid_next;
    logic [4:0]     m_row_reg;
    logic [6:0]     m_col_reg;
    logic [11:0]    m_addr_reg;
    logic [7:0]     m_char_reg;
    logic [7:0]     m_attr_reg;
    logic           m_scr_reg;
    logic           out_load;

    // Memory port.
    logic [15:0]    mem [DEPTH];
    logic           mem_we;
    logic           mem_re;
    logic [AW-1:0]  mem_addr;
    logic [15:0]    mem_wdata;
    logic [15:0]    rd_data_reg;

    // Effective geometry and derived flags.
    logic [RW-1:0]  rows_eff;
    logic [CW-1:0]  cols_eff;
    logic           row_last;
    logic           col_last;
    logic           rd_in_range;
    logic [RIW-1:0] phys_cur;
    logic [RIW-1:0] phys_rd;
    logic [RIW-1:0] top_inc;
    logic [AFW-1:0] addr_full;

    // Physical row of a visible row: both are below the row count, so one subtract suffices.
    function automatic logic [RIW-1:0] phys_row(input logic [RIW-1:0] top,
                                                input logic [RIW-1:0] vis,
                                                input logic [RW-1:0]  rows);
        logic [PW-1:0] sum;
        sum = {1'b0, top} + {1'b0, vis};
        if (sum >= PW'(rows)) begin
            sum = sum - PW'(rows);
        end
        return sum[RIW-1:0];
    endfunction

    // Rows and columns saturated to their legal ranges.
    always_comb begin
        if (rows_reg == 6'd0) begin
            rows_eff = RW'(1);
        end else if ({1'b0, rows_reg} > RCMPW'(MAX_ROWS)) begin
            rows_eff = RW'(MAX_ROWS);
        end else begin
            rows_eff = RW'(rows_reg);
        end
        if (cols_reg < 8'd2) begin
            cols_eff = CW'(2);
        end else if ({1'b0, cols_reg} > CCMPW'(MAX_COLS)) begin
            cols_eff = CW'(MAX_COLS);
        end else begin
            cols_eff = CW'(cols_reg);
        end
    end

    // Cursor position flags and physical rows, valid once the cursor is normalized.
    assign row_last    = (RW'(row_reg) == rows_eff - RW'(1));
    assign col_last    = (CW'(col_reg) == cols_eff - CW'(1));
    assign rd_in_range = (RCMPW'(rrow_reg) < RCMPW'(rows_eff)) &&
                         (CCMPW'(rcol_reg) < CCMPW'(cols_eff));
    assign phys_cur    = phys_row(top_reg, row_reg, rows_eff);
    assign phys_rd     = phys_row(top_reg, RIW'(rrow_reg), rows_eff);
    assign top_inc     = (RW'(top_reg) == rows_eff - RW'(1)) ? '0 : top_reg + RIW'(1);
    assign addr_full   = AFW'(row_reg) * AFW'(cols_eff) + AFW'(col_reg);

    assign out_load = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    assign m_cursor_row     = m_row_reg;
    assign m_cursor_col     = m_col_reg;
    assign m_cursor_address = m_addr_reg;
    assign m_read_char      = m_char_reg;
    assign m_read_attr      = m_attr_reg;
    assign m_scrolled       = m_scr_reg;

    // Item sequencer.
    always_comb begin
        state_next     = state_reg;
        top_next       = top_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rchar_next     = rchar_reg;
        rattr_next     = rattr_reg;
        scr_next       = scr_reg;
        clr_cnt_next   = clr_cnt_reg;
        swp_cnt_next   = swp_cnt_reg;
        blank_row_next = blank_row_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = {phys_cur, col_reg};
        mem_wdata      = {attr_reg, tcw_pkg::CH_SPACE};

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                rchar_next = 8'd0;
                rattr_next = 8'd0;
                scr_next   = 1'b0;
                if (s_valid) begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                // Reduce the top-row offset by repeated subtraction, then clamp the cursor.
                if (RW'(top_reg) >= rows_eff) begin
                    top_next = top_reg - RIW'(rows_eff);
                end else begin
                    if (RW'(row_reg) >= rows_eff) begin
                        row_next = RIW'(rows_eff - RW'(1));
                    end
                    if (CW'(col_reg) >= cols_eff) begin
                        col_next = CIW'(cols_eff - CW'(1));
                    end
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                if (func_reg == tcw_pkg::FUNC_READ) begin
                    if (rd_in_range) begin
                        mem_re     = 1'b1;
                        mem_addr   = {phys_rd, CIW'(rcol_reg)};
                        state_next = ST_RDWAIT;
                    end
                end else begin
                    case (char_reg)
                        tcw_pkg::CH_CR: begin
                            col_next = '0;
                        end
                        tcw_pkg::CH_LF: begin
                            col_next = '0;
                            if (row_last) begin
                                top_next       = top_inc;
                                blank_row_next = top_reg;
                                swp_cnt_next   = '0;
                                scr_next       = 1'b1;
                                state_next     = ST_SCROLL;
                            end else begin
                                row_next = row_reg + RIW'(1);
                            end
                        end
                        tcw_pkg::CH_BS: begin
                            if (col_reg != '0) begin
                                col_next = col_reg - CIW'(1);
                                mem_we   = 1'b1;
                                mem_addr = {phys_cur, col_reg - CIW'(1)};
                            end
                        end
                        default: begin
                            mem_we    = 1'b1;
                            mem_wdata = {attr_reg, char_reg};
                            if (col_last) begin
                                col_next = '0;
                                if (row_last) begin
                                    top_next       = top_inc;
                                    blank_row_next = top_reg;
                                    swp_cnt_next   = '0;
                                    scr_next       = 1'b1;
                                    state_next     = ST_SCROLL;
                                end else begin
                                    row_next = row_reg + RIW'(1);
                                end
                            end else begin
                                col_next = col_reg + CIW'(1);
                            end
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                rchar_next = rd_data_reg[7:0];
                rattr_next = rd_data_reg[15:8];
                state_next = ST_DONE;
            end
            ST_SCROLL: begin
                // Blank every cell of the row that becomes the last visible row.
                mem_we       = 1'b1;
                mem_addr     = {blank_row_reg, swp_cnt_reg};
                swp_cnt_next = swp_cnt_reg + CIW'(1);
                if (swp_cnt_reg == CIW'(MAX_COLS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and console state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            rows_reg      <= tcw_pkg::RESET_ROWS;
            cols_reg      <= tcw_pkg::RESET_COLS;
            attr_reg      <= tcw_pkg::RESET_ATTR;
            top_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            clr_cnt_reg   <= '0;
            swp_cnt_reg   <= '0;
            blank_row_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            clr_cnt_reg   <= clr_cnt_next;
            swp_cnt_reg   <= swp_cnt_next;
            blank_row_reg <= blank_row_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tcw_pkg::REG_ROWS: rows_reg <= cfg_data[5:0];
                    tcw_pkg::REG_COLS: cols_reg <= cfg_data;
                    tcw_pkg::REG_ATTR: attr_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Item capture, partial result and output payload.
    always_ff @(posedge aclk) begin
        rchar_reg <= rchar_next;
        rattr_reg <= rattr_next;
        scr_reg   <= scr_next;
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            char_reg <= s_char_code;
            rrow_reg <= s_read_row;
            rcol_reg <= s_read_col;
        end
        if (state_reg == ST_DONE && out_load) begin
            m_row_reg  <= 5'(row_reg);
            m_col_reg  <= 7'(col_reg);
            m_addr_reg <= 12'(addr_full);
            m_char_reg <= rchar_reg;
            m_attr_reg <= rattr_reg;
            m_scr_reg  <= scr_reg;
        end
    end

    // Cell store: one write or one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

endmodule

`default_nettype wire

// File: verif/tb_text_console_writer_top.sv
// Self-checking testbench for the text console writer: directed and random beats, scoreboarded.
`timescale 1ns / 100ps

module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam int ROWS_CAP = MAX_ROWS_DEF;
    localparam int COLS_CAP = MAX_COLS_DEF;
    localparam int CELL_COUNT = ROWS_CAP * COLS_CAP;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS = 150;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } console_cmd_t;

    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [11:0] addr;
        logic [7:0]  rd_char;
        logic [7:0]  rd_attr;
        logic        scrolled;
    } console_status_t;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_STALLS} ready_mode_t;

    // Shadow copy of the console: cell store, cursor, scroll offset and registers.
    class console_scoreboard;
        logic [15:0] cells [CELL_COUNT];
        int unsigned top_row;
        int unsigned cur_row;
        int unsigned cur_col;
        logic [5:0]  rows_reg;
        logic [7:0]  cols_reg;
        logic [7:0]  attr_reg;
        console_status_t awaited [$];
        int unsigned mismatches;
        int unsigned result_count;

        function new();
            foreach (cells[i]) cells[i] = {RESET_ATTR, CH_SPACE};
            top_row = 0;
            cur_row = 0;
            cur_col = 0;
            rows_reg = RESET_ROWS;
            cols_reg = RESET_COLS;
            attr_reg = RESET_ATTR;
            mismatches = 0;
            result_count = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                REG_ROWS: rows_reg = data[5:0];
                REG_COLS: cols_reg = data;
                REG_ATTR: attr_reg = data;
                default: ;
            endcase
        endfunction

        // Register values are used saturated to the legal geometry.
        function int unsigned rows_eff();
            int unsigned r;
            r = rows_reg;
            if (r < 1) r = 1;
            if (r > ROWS_CAP) r = ROWS_CAP;
            return r;
        endfunction

        function int unsigned cols_eff();
            int unsigned c;
            c = cols_reg;
            if (c < 2) c = 2;
            if (c > COLS_CAP) c = COLS_CAP;
            return c;
        endfunction

        function void cell_write(int unsigned rows, logic [7:0] ch);
            cells[((top_row + cur_row) % rows) * COLS_CAP + cur_col] = {attr_reg, ch};
        endfunction

        // Move the cursor down one row; past the bottom the screen scrolls and the
        // new last row (the whole physical row) is blanked.
        function bit line_down(int unsigned rows);
            int unsigned base;
            int unsigned c;
            cur_row++;
            if (cur_row < rows) return 1'b0;
            cur_row = rows - 1;
            top_row = (top_row + 1) % rows;
            base = ((top_row + rows - 1) % rows) * COLS_CAP;
            for (c = 0; c < COLS_CAP; c++) cells[base + c] = {attr_reg, CH_SPACE};
            return 1'b1;
        endfunction

        // Apply one accepted input beat and queue the status it must produce.
        function void note_item(console_cmd_t c);
            int unsigned rows;
            int unsigned cols;
            int unsigned idx;
            console_status_t want;
            rows = rows_eff();
            cols = cols_eff();
            want = '0;

            // A geometry change takes effect at the start of the next item.
            top_row = top_row % rows;
            if (cur_row >= rows) cur_row = rows - 1;
            if (cur_col >= cols) cur_col = cols - 1;

            if (c.func == FUNC_READ) begin
                if (c.read_row < rows && c.read_col < cols) begin
                    idx = ((top_row + c.read_row) % rows) * COLS_CAP + c.read_col;
                    want.rd_char = cells[idx][7:0];
                    want.rd_attr = cells[idx][15:8];
                end
            end else begin
                case (c.char_code)
                    CH_CR: cur_col = 0;
                    CH_LF: begin
                        cur_col = 0;
                        want.scrolled = line_down(rows);
                    end
                    CH_BS: begin
                        if (cur_col > 0) begin
                            cur_col--;
                            cell_write(rows, CH_SPACE);
                        end
                    end
                    default: begin
                        cell_write(rows, c.char_code);
                        cur_col++;
                        if (cur_col >= cols) begin
                            cur_col = 0;
                            want.scrolled = line_down(rows);
                        end
                    end
                endcase
            end

            want.row = 5'(cur_row);
            want.col = 7'(cur_col);
            want.addr = 12'(cur_row * cols + cur_col);
            awaited.push_back(want);
        endfunction

        function void check_field(string name, logic [11:0] want, logic [11:0] got);
            if (want === got) return;
            if (mismatches < REPORT_LIMIT)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         result_count, name, want, got);
            mismatches++;
        endfunction

        // Compare one result beat against the oldest queued status.
        function void check_result(console_status_t got);
            console_status_t want;
            result_count++;
            if (awaited.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("result %0d: beat arrived with no item waiting for it",
                             result_count);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            check_field("cursor_row", want.row, got.row);
            check_field("cursor_col", want.col, got.col);
            check_field("cursor_address", want.addr, got.addr);
            check_field("read_char", want.rd_char, got.rd_char);
            check_field("read_attr", want.rd_attr, got.rd_attr);
            check_field("scrolled", want.scrolled, got.scrolled);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [7:0]  s_char_code = '0;
    logic [4:0]  s_read_row = '0;
    logic [6:0]  s_read_col = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_cursor_row;
    logic [6:0]  m_cursor_col;
    logic [11:0] m_cursor_address;
    logic [7:0]  m_read_char;
    logic [7:0]  m_read_attr;
    logic        m_scrolled;

    console_scoreboard sb;
    int unsigned burst_left = 0;
    bit          gaps_on = 1'b1;
    int unsigned lf_share = 10;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int unsigned mode_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    text_console_writer_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_char_code      (s_char_code),
        .s_read_row       (s_read_row),
        .s_read_col       (s_read_col),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_row     (m_cursor_row),
        .m_cursor_col     (m_cursor_col),
        .m_cursor_address (m_cursor_address),
        .m_read_char      (m_read_char),
        .m_read_attr      (m_read_attr),
        .m_scrolled       (m_scrolled)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check every beat taken, and stall in modes that change over time.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(console_status_t'({m_cursor_row, m_cursor_col, m_cursor_address,
                                                m_read_char, m_read_attr, m_scrolled}));
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_RANDOM: m_ready <= ($urandom_range(0, 9) < 7);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(1, 16);
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    function automatic console_cmd_t put_cmd(logic [7:0] ch);
        console_cmd_t c;
        c = '0;
        c.func = FUNC_PUT;
        c.char_code = ch;
        return c;
    endfunction

    function automatic console_cmd_t read_cmd(logic [4:0] row, logic [6:0] col);
        console_cmd_t c;
        c = '0;
        c.func = FUNC_READ;
        c.read_row = row;
        c.read_col = col;
        return c;
    endfunction

    // Printable text, random bytes and line control; reads favor the visible
    // screen and the cursor's own row. Unused fields carry random bits.
    function automatic console_cmd_t random_cmd();
        console_cmd_t c;
        int unsigned rows;
        int unsigned cols;
        int unsigned k;
        rows = sb.rows_eff();
        cols = sb.cols_eff();
        c.func = FUNC_PUT;
        c.char_code = 8'($urandom);
        c.read_row = 5'($urandom);
        c.read_col = 7'($urandom);
        k = $urandom_range(0, 99);
        if (k < 25) begin
            c.func = FUNC_READ;
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 1) == 0 && sb.cur_row < rows)
                    c.read_row = 5'(sb.cur_row);
                else
                    c.read_row = 5'($urandom_range(0, rows - 1));
                c.read_col = 7'($urandom_range(0, cols - 1));
            end
        end else begin
            k = $urandom_range(0, 99);
            if (k < lf_share) c.char_code = CH_LF;
            else if (k < lf_share + 5) c.char_code = CH_CR;
            else if (k < lf_share + 13) c.char_code = CH_BS;
            else if (k >= lf_share + 30) c.char_code = 8'($urandom_range(8'h20, 8'h7E));
        end
        return c;
    endfunction

    // Present one beat and hold it until the block takes it.
    task automatic send_cmd(input console_cmd_t c);
        s_valid <= 1'b1;
        s_func <= c.func;
        s_char_code <= c.char_code;
        s_read_row <= c.read_row;
        s_read_col <= c.read_col;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(c);
    endtask

    task automatic hold_off(input int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Beats go out in bursts of random length, with random gaps when enabled.
    task automatic send_paced(input console_cmd_t c);
        if (burst_left == 0) begin
            if (gaps_on) hold_off($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_cmd(c);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // Registers change only once every queued result has come back.
    task automatic configure(input logic [7:0] rows_data, input logic [7:0] cols_data,
                             input logic [7:0] attr_data, input bit poke_unused);
        wait_drained();
        reg_write(REG_ROWS, rows_data);
        reg_write(REG_COLS, cols_data);
        reg_write(REG_ATTR, attr_data);
        if (poke_unused) reg_write(REG_UNUSED, 8'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int p;
        int n;
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: blank store, edges of the screen, control bytes.
        send_paced(read_cmd(5'd0, 7'd0));
        send_paced(read_cmd(5'd31, 7'd127));
        send_paced(read_cmd(5'd24, 7'd79));
        send_paced(read_cmd(5'd25, 7'd0));
        send_paced(read_cmd(5'd0, 7'd80));
        send_paced(put_cmd(CH_BS));
        send_paced(put_cmd(8'h00));
        send_paced(put_cmd(8'hFF));
        send_paced(put_cmd(8'h41));
        send_paced(put_cmd(CH_BS));
        send_paced(read_cmd(5'd0, 7'd1));
        send_paced(put_cmd(CH_CR));
        send_paced(put_cmd(CH_LF));
        send_paced(read_cmd(5'd0, 7'd0));

        // Smallest screen: every wrap and every line feed scrolls.
        configure(8'd1, 8'd2, 8'h00, 1'b0);
        send_paced(put_cmd(8'h78));
        send_paced(read_cmd(5'd0, 7'd0));
        send_paced(put_cmd(8'h79));
        send_paced(put_cmd(8'h7A));
        send_paced(read_cmd(5'd0, 7'd1));
        send_paced(put_cmd(CH_LF));
        send_paced(put_cmd(CH_CR));
        send_paced(put_cmd(CH_BS));
        send_paced(read_cmd(5'd1, 7'd0));

        // Random phases, each under its own geometry and pacing.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            lf_share = 10;
            case (p)
                0: begin
                    configure(8'd32, 8'd128, 8'hFF, 1'b0);
                    lf_share = 35;
                end
                1: configure(8'd1, 8'd2, 8'h00, 1'b0);
                2: configure(8'd0, 8'd0, 8'($urandom), 1'b1);
                3: begin
                    configure(8'hFF, 8'hFF, 8'($urandom), 1'b1);
                    lf_share = 35;
                end
                4: begin
                    configure(8'd33, 8'd129, 8'($urandom), 1'b0);
                    lf_share = 35;
                end
                5: configure({2'b11, 6'd2}, 8'd1, 8'($urandom), 1'b0);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        configure({2'($urandom), 6'($urandom_range(1, 32))},
                                  8'($urandom_range(2, 128)), 8'($urandom), 1'b0);
                    else
                        configure({2'($urandom), 6'($urandom_range(1, 6))},
                                  8'($urandom_range(2, 12)), 8'($urandom),
                                  $urandom_range(0, 1));
                end
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_ITEMS; n++) send_paced(random_cmd());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: text_console_writer_top.f
rtl/tcw_pkg.sv
rtl/text_console_writer_top.sv
verif/tb_text_console_writer_top.sv
